FILE: src/fit_block_allocator_macros.svh
// Assertion macros for the fit block allocator.
// Used by fba_free_list and fit_block_allocator; no other dependencies.
`ifndef FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_BLOCK_ALLOCATOR_MACROS_SVH

// ante implies cons in the same cycle
`define FBA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fba assertion failed");

// ante implies cons in the next cycle
`define FBA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fba assertion failed");

`endif

FILE: src/fba_pkg.sv
// Shared types, constants and reset tables for the fit block allocator.
// No dependencies.
`default_nettype none

package fba_pkg;

   localparam int FREE_DEPTH = 16;
   localparam int USED_DEPTH = 32;
   localparam int ADDR_BITS  = 24;
   localparam int LEN_BITS   = 25;
   localparam int ID_BITS    = 8;
   localparam int FREED_BITS = 6;
   localparam int STAT_BITS  = 2;
   localparam int TYPE_BITS  = 2;
   localparam int CSR_IDX_BITS = 1;
   localparam int FIDX_BITS  = $clog2(FREE_DEPTH);
   localparam int FCNT_BITS  = $clog2(FREE_DEPTH + 1);
   localparam int UIDX_BITS  = $clog2(USED_DEPTH);
   localparam int UCNT_BITS  = $clog2(USED_DEPTH + 1);
   localparam int WIDE_BITS  = ((ADDR_BITS > LEN_BITS) ? ADDR_BITS : LEN_BITS) + 1;
   localparam int MB         = 1024 * 1024;
   localparam int INIT_COUNT = 5;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [LEN_BITS-1:0]  len_type;
   typedef logic [WIDE_BITS-1:0] wide_type;

   // request codes
   localparam logic [TYPE_BITS-1:0] REQ_ALLOC = 2'd0;
   localparam logic [TYPE_BITS-1:0] REQ_FREE  = 2'd1;
   localparam logic [TYPE_BITS-1:0] REQ_TERM  = 2'd2;

   // status codes
   localparam logic [STAT_BITS-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_BITS-1:0] ST_NO_SPACE  = 2'd1;
   localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STAT_BITS-1:0] ST_FULL      = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_FIT_MODE    = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MERGE_LIMIT = 1'b1;

   localparam len_type MERGE_LIMIT_RESET = LEN_BITS'(4 * MB);

   typedef enum logic [2:0] {
      FL_NOP    = 3'd0,
      FL_UPDATE = 3'd1,
      FL_REMOVE = 3'd2,
      FL_INSERT = 3'd3,
      FL_MERGE  = 3'd4
   } fl_op_type;

   typedef struct packed {
      fl_op_type              op;
      logic [FIDX_BITS-1:0]   idx;
      addr_type               start;
      len_type                len;
   } fl_cmd_type;

   function automatic addr_type init_start(input int i);
      addr_type r;
      case (i)
         0: r = ADDR_BITS'(3 * MB);
         1: r = ADDR_BITS'(4 * MB);
         2: r = ADDR_BITS'(5 * MB);
         3: r = ADDR_BITS'(8 * MB);
         4: r = ADDR_BITS'(12 * MB);
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic len_type init_len(input int i);
      len_type r;
      case (i)
         0: r = LEN_BITS'(1 * MB);
         1: r = LEN_BITS'(2 * MB);
         2: r = LEN_BITS'(2 * MB);
         3: r = LEN_BITS'(4 * MB);
         4: r = LEN_BITS'(4 * MB);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: src/fit_block_allocator.sv
// Top level of the fit block allocator: request sequencer, used-block table
// and config registers. Uses fba_pkg, fba_free_list and the assertion macros.
//
//  channel   ports                                   transfer when
//  request   start, busy, req_type/owner_id/...      start & !busy
//  response  rsp_strobe, rsp_status/alloc_addr/...   rsp_strobe (one cycle)
//  config    csr_we, csr_index, csr_wdata            csr_we
//
// One request at a time; busy stays high from the transfer to the response.
// Allocate: a fit scan over the free list (up to 16 entries), a carve, then the response.
// Free/terminate: a used-table scan (one entry a cycle, up to 32), per
// released block an insert-position scan (up to 16) and an insert, then one
// merge walk over the free list (one pair per cycle).
// The free-list read port and the single sequencer bound the rate.
// Synchronous reset restores the five initial free blocks at once; no pass.
// The receiver cannot stall: the response is shown for one cycle only.
`default_nettype none
`include "fit_block_allocator_macros.svh"

module fit_block_allocator (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [fba_pkg::TYPE_BITS-1:0]    req_type,
   input  wire logic [fba_pkg::ID_BITS-1:0]      req_owner_id,
   input  wire logic [fba_pkg::ID_BITS-1:0]      req_block_id,
   input  wire logic [fba_pkg::LEN_BITS-1:0]     req_size,
   output logic                                  rsp_strobe,
   output logic [fba_pkg::STAT_BITS-1:0]         rsp_status,
   output logic [fba_pkg::ADDR_BITS-1:0]         rsp_alloc_addr,
   output logic [fba_pkg::FREED_BITS-1:0]        rsp_freed_count,
   input  wire logic                             csr_we,
   input  wire logic [fba_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [fba_pkg::LEN_BITS-1:0]     csr_wdata
);

   localparam int FIDX = fba_pkg::FIDX_BITS;
   localparam int FCNT = fba_pkg::FCNT_BITS;
   localparam int UIDX = fba_pkg::UIDX_BITS;
   localparam int UCNT = fba_pkg::UCNT_BITS;
   localparam int WIDE = fba_pkg::WIDE_BITS;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_A_SCAN = 9'b000000010,  // fit search over the free list
      S_A_UPD  = 9'b000000100,  // carve block, push used entry
      S_U_SCAN = 9'b000001000,  // look for a matching used entry
      S_F_POS  = 9'b000010000,  // find sorted insert position
      S_F_INS  = 9'b000100000,  // insert free block, drop used entry
      S_M_LOAD = 9'b001000000,  // load first free entry for merging
      S_M_STEP = 9'b010000000,  // merge walk, one pair per cycle
      S_DONE   = 9'b100000000   // response strobe
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic [fba_pkg::TYPE_BITS-1:0] type_ff, type_in;
   logic [fba_pkg::ID_BITS-1:0]   owner_ff, owner_in, tag_ff, tag_in;
   fba_pkg::len_type              size_ff, size_in;

   // config
   logic             fit_mode_ff, fit_mode_in;
   fba_pkg::len_type merge_limit_ff, merge_limit_in;

   // sequencer working registers
   logic [UCNT-1:0]   used_n_ff, used_n_in, k_ff, k_in, freed_ff, freed_in;
   logic [FCNT-1:0]   idx_ff, idx_in;
   logic [FIDX-1:0]   best_ff, best_in;
   fba_pkg::len_type  best_len_ff, best_len_in;
   logic              found_ff, found_in, full_ff, full_in;
   logic [fba_pkg::STAT_BITS-1:0] status_ff, status_in;
   fba_pkg::addr_type addr_ff, addr_in;
   fba_pkg::addr_type ins_start_ff, ins_start_in, cur_start_ff, cur_start_in;
   fba_pkg::len_type  ins_len_ff, ins_len_in, cur_len_ff, cur_len_in;

   // used-block table, newest at index 0
   fba_pkg::addr_type            used_start_ff [fba_pkg::USED_DEPTH];
   fba_pkg::len_type             used_len_ff   [fba_pkg::USED_DEPTH];
   logic [fba_pkg::ID_BITS-1:0]  used_owner_ff [fba_pkg::USED_DEPTH];
   logic [fba_pkg::ID_BITS-1:0]  used_tag_ff   [fba_pkg::USED_DEPTH];
   fba_pkg::addr_type            used_start_in [fba_pkg::USED_DEPTH];
   fba_pkg::len_type             used_len_in   [fba_pkg::USED_DEPTH];
   logic [fba_pkg::ID_BITS-1:0]  used_owner_in [fba_pkg::USED_DEPTH];
   logic [fba_pkg::ID_BITS-1:0]  used_tag_in   [fba_pkg::USED_DEPTH];
   logic used_push, used_pop;

   // free list port
   fba_pkg::fl_cmd_type fl_cmd;
   logic [FIDX-1:0]     fl_rd_idx;
   fba_pkg::addr_type   fl_rd_start;
   fba_pkg::len_type    fl_rd_len;
   logic [FCNT-1:0]     fl_count;

   // scratch
   logic hit, take, match;
   fba_pkg::len_type new_len;
   fba_pkg::wide_type sum_w, end_w;

   fba_free_list u_free_list (
      .clock    (clock),
      .reset    (reset),
      .cmd      (fl_cmd),
      .rd_idx   (fl_rd_idx),
      .rd_start (fl_rd_start),
      .rd_len   (fl_rd_len),
      .count    (fl_count)
   );

   // read port select: carve uses the chosen entry, merge starts at entry 0
   always_comb begin
      case (state_ff)
         S_A_UPD:  fl_rd_idx = best_ff;
         S_M_LOAD: fl_rd_idx = '0;
         default:  fl_rd_idx = idx_ff[FIDX-1:0];
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      type_in        = type_ff;
      owner_in       = owner_ff;
      tag_in         = tag_ff;
      size_in        = size_ff;
      fit_mode_in    = fit_mode_ff;
      merge_limit_in = merge_limit_ff;
      used_n_in      = used_n_ff;
      k_in           = k_ff;
      freed_in       = freed_ff;
      idx_in         = idx_ff;
      best_in        = best_ff;
      best_len_in    = best_len_ff;
      found_in       = found_ff;
      full_in        = full_ff;
      status_in      = status_ff;
      addr_in        = addr_ff;
      ins_start_in   = ins_start_ff;
      ins_len_in     = ins_len_ff;
      cur_start_in   = cur_start_ff;
      cur_len_in     = cur_len_ff;
      fl_cmd         = '0;
      used_push      = 1'b0;
      used_pop       = 1'b0;
      hit            = fl_rd_len >= size_ff;
      take           = hit && (!found_ff || (fit_mode_ff && fl_rd_len < best_len_ff));
      match          = used_owner_ff[k_ff[UIDX-1:0]] == owner_ff &&
                       (type_ff == fba_pkg::REQ_TERM || used_tag_ff[k_ff[UIDX-1:0]] == tag_ff);
      new_len        = best_len_ff - size_ff;
      sum_w          = '0;
      end_w          = '0;

      if (csr_we) begin
         case (csr_index)
            fba_pkg::CSR_FIT_MODE:    fit_mode_in = csr_wdata[0];
            fba_pkg::CSR_MERGE_LIMIT: merge_limit_in = csr_wdata;
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               type_in   = req_type;
               owner_in  = req_owner_id;
               tag_in    = req_block_id;
               size_in   = req_size;
               freed_in  = '0;
               full_in   = 1'b0;
               found_in  = 1'b0;
               addr_in   = '0;
               status_in = fba_pkg::ST_OK;
               k_in      = '0;
               idx_in    = '0;
               case (req_type)
                  fba_pkg::REQ_ALLOC: begin
                     if (used_n_ff == UCNT'(fba_pkg::USED_DEPTH)) begin
                        status_in = fba_pkg::ST_FULL;
                        state_in  = S_DONE;
                     end else if (fl_count == '0) begin
                        status_in = fba_pkg::ST_NO_SPACE;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_A_SCAN;
                     end
                  end
                  fba_pkg::REQ_FREE, fba_pkg::REQ_TERM: state_in = S_U_SCAN;
                  default: state_in = S_DONE;
               endcase
            end
         end

         S_A_SCAN: begin
            if (take) begin
               best_in     = idx_ff[FIDX-1:0];
               best_len_in = fl_rd_len;
            end
            if (hit) begin
               found_in = 1'b1;
            end
            if (hit && !fit_mode_ff) begin
               state_in = S_A_UPD;
            end else if (idx_ff + 1'b1 == fl_count) begin
               if (found_ff || hit) begin
                  state_in = S_A_UPD;
               end else begin
                  status_in = fba_pkg::ST_NO_SPACE;
                  state_in  = S_DONE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_A_UPD: begin
            sum_w      = WIDE'(fl_rd_start) + WIDE'(size_ff);
            addr_in    = fl_rd_start;
            fl_cmd.idx = best_ff;
            if (new_len == '0) begin
               fl_cmd.op = fba_pkg::FL_REMOVE;
            end else begin
               fl_cmd.op    = fba_pkg::FL_UPDATE;
               fl_cmd.start = sum_w[fba_pkg::ADDR_BITS-1:0];
               fl_cmd.len   = new_len;
            end
            used_push = 1'b1;
            used_n_in = used_n_ff + 1'b1;
            state_in  = S_DONE;
         end

         S_U_SCAN: begin
            if (k_ff >= used_n_ff) begin
               if (type_ff == fba_pkg::REQ_TERM && freed_ff != '0) begin
                  state_in = S_M_LOAD;
               end else begin
                  status_in = fba_pkg::ST_NOT_FOUND;
                  state_in  = S_DONE;
               end
            end else if (match) begin
               if (fl_count == FCNT'(fba_pkg::FREE_DEPTH)) begin
                  // free list full: this block stays in use
                  full_in = 1'b1;
                  if (type_ff == fba_pkg::REQ_TERM && freed_ff != '0) begin
                     state_in = S_M_LOAD;
                  end else begin
                     status_in = fba_pkg::ST_FULL;
                     state_in  = S_DONE;
                  end
               end else begin
                  ins_start_in = used_start_ff[k_ff[UIDX-1:0]];
                  ins_len_in   = used_len_ff[k_ff[UIDX-1:0]];
                  idx_in       = '0;
                  state_in     = S_F_POS;
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end

         S_F_POS: begin
            if (idx_ff < fl_count && !(ins_start_ff < fl_rd_start)) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = S_F_INS;
            end
         end

         S_F_INS: begin
            fl_cmd.op    = fba_pkg::FL_INSERT;
            fl_cmd.idx   = idx_ff[FIDX-1:0];
            fl_cmd.start = ins_start_ff;
            fl_cmd.len   = ins_len_ff;
            used_pop     = 1'b1;
            used_n_in    = used_n_ff - 1'b1;
            freed_in     = freed_ff + 1'b1;
            // terminate rescans from the same slot, which now holds the next entry
            state_in     = (type_ff == fba_pkg::REQ_FREE) ? S_M_LOAD : S_U_SCAN;
         end

         S_M_LOAD: begin
            cur_start_in = fl_rd_start;
            cur_len_in   = fl_rd_len;
            idx_in       = FCNT'(1);
            state_in     = S_M_STEP;
         end

         S_M_STEP: begin
            end_w = WIDE'(cur_start_ff) + WIDE'(cur_len_ff);
            sum_w = WIDE'(cur_len_ff) + WIDE'(fl_rd_len);
            if (idx_ff >= fl_count) begin
               status_in = full_ff ? fba_pkg::ST_FULL : fba_pkg::ST_OK;
               state_in  = S_DONE;
            end else if (end_w == WIDE'(fl_rd_start) && sum_w <= WIDE'(merge_limit_ff)) begin
               fl_cmd.op  = fba_pkg::FL_MERGE;
               fl_cmd.idx = idx_ff[FIDX-1:0];
               fl_cmd.len = sum_w[fba_pkg::LEN_BITS-1:0];
               cur_len_in = sum_w[fba_pkg::LEN_BITS-1:0];
            end else begin
               cur_start_in = fl_rd_start;
               cur_len_in   = fl_rd_len;
               idx_in       = idx_ff + 1'b1;
            end
         end

         S_DONE: state_in = S_IDLE;

         default: state_in = S_IDLE;
      endcase
   end

   // used table shifts: push at the front, pop closes the gap at k
   always_comb begin
      for (int j = 0; j < fba_pkg::USED_DEPTH; j++) begin
         used_start_in[j] = used_start_ff[j];
         used_len_in[j]   = used_len_ff[j];
         used_owner_in[j] = used_owner_ff[j];
         used_tag_in[j]   = used_tag_ff[j];
         if (used_push) begin
            if (j == 0) begin
               used_start_in[j] = fl_rd_start;
               used_len_in[j]   = size_ff;
               used_owner_in[j] = owner_ff;
               used_tag_in[j]   = tag_ff;
            end else begin
               used_start_in[j] = used_start_ff[(j + fba_pkg::USED_DEPTH - 1) % fba_pkg::USED_DEPTH];
               used_len_in[j]   = used_len_ff[(j + fba_pkg::USED_DEPTH - 1) % fba_pkg::USED_DEPTH];
               used_owner_in[j] = used_owner_ff[(j + fba_pkg::USED_DEPTH - 1) % fba_pkg::USED_DEPTH];
               used_tag_in[j]   = used_tag_ff[(j + fba_pkg::USED_DEPTH - 1) % fba_pkg::USED_DEPTH];
            end
         end else if (used_pop && j >= int'(k_ff)) begin
            used_start_in[j] = used_start_ff[(j + 1) % fba_pkg::USED_DEPTH];
            used_len_in[j]   = used_len_ff[(j + 1) % fba_pkg::USED_DEPTH];
            used_owner_in[j] = used_owner_ff[(j + 1) % fba_pkg::USED_DEPTH];
            used_tag_in[j]   = used_tag_ff[(j + 1) % fba_pkg::USED_DEPTH];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         fit_mode_ff    <= 1'b0;
         merge_limit_ff <= fba_pkg::MERGE_LIMIT_RESET;
         used_n_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         fit_mode_ff    <= fit_mode_in;
         merge_limit_ff <= merge_limit_in;
         used_n_ff      <= used_n_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff      <= type_in;
      owner_ff     <= owner_in;
      tag_ff       <= tag_in;
      size_ff      <= size_in;
      k_ff         <= k_in;
      freed_ff     <= freed_in;
      idx_ff       <= idx_in;
      best_ff      <= best_in;
      best_len_ff  <= best_len_in;
      found_ff     <= found_in;
      full_ff      <= full_in;
      status_ff    <= status_in;
      addr_ff      <= addr_in;
      ins_start_ff <= ins_start_in;
      ins_len_ff   <= ins_len_in;
      cur_start_ff <= cur_start_in;
      cur_len_ff   <= cur_len_in;
      for (int j = 0; j < fba_pkg::USED_DEPTH; j++) begin
         used_start_ff[j] <= used_start_in[j];
         used_len_ff[j]   <= used_len_in[j];
         used_owner_ff[j] <= used_owner_in[j];
         used_tag_ff[j]   <= used_tag_in[j];
      end
   end

   assign busy            = state_ff != S_IDLE;
   assign rsp_strobe      = state_ff == S_DONE;
   assign rsp_status      = status_ff;
   assign rsp_alloc_addr  = addr_ff;
   assign rsp_freed_count = fba_pkg::FREED_BITS'(freed_ff);

   `FBA_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `FBA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `FBA_ASSERT_NOW(a_freed_found, clock, reset, rsp_strobe && rsp_freed_count != '0, rsp_status != fba_pkg::ST_NOT_FOUND)
   `FBA_ASSERT_NOW(a_used_bound, clock, reset, 1'b1, used_n_ff <= UCNT'(fba_pkg::USED_DEPTH))

endmodule

`default_nettype wire

FILE: src/fba_free_list.sv
// Address-sorted free list: entry storage with one read port and registered
// update, insert, remove and merge shifts. Uses fba_pkg.
`default_nettype none
`include "fit_block_allocator_macros.svh"

module fba_free_list (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire fba_pkg::fl_cmd_type           cmd,
   input  wire logic [fba_pkg::FIDX_BITS-1:0] rd_idx,
   output fba_pkg::addr_type                  rd_start,
   output fba_pkg::len_type                   rd_len,
   output logic [fba_pkg::FCNT_BITS-1:0]      count
);

   fba_pkg::addr_type start_ff [fba_pkg::FREE_DEPTH];
   fba_pkg::len_type  len_ff   [fba_pkg::FREE_DEPTH];
   fba_pkg::addr_type start_in [fba_pkg::FREE_DEPTH];
   fba_pkg::len_type  len_in   [fba_pkg::FREE_DEPTH];
   logic [fba_pkg::FCNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      for (int j = 0; j < fba_pkg::FREE_DEPTH; j++) begin
         start_in[j] = start_ff[j];
         len_in[j]   = len_ff[j];
         case (cmd.op)
            fba_pkg::FL_UPDATE: begin
               if (j == int'(cmd.idx)) begin
                  start_in[j] = cmd.start;
                  len_in[j]   = cmd.len;
               end
            end
            fba_pkg::FL_REMOVE, fba_pkg::FL_MERGE: begin
               if (j >= int'(cmd.idx)) begin
                  if (j < fba_pkg::FREE_DEPTH - 1) begin
                     start_in[j] = start_ff[(j + 1) % fba_pkg::FREE_DEPTH];
                     len_in[j]   = len_ff[(j + 1) % fba_pkg::FREE_DEPTH];
                  end else begin
                     start_in[j] = '0;
                     len_in[j]   = '0;
                  end
               end
               // merge folds the removed entry into its lower neighbor
               if (cmd.op == fba_pkg::FL_MERGE && j + 1 == int'(cmd.idx)) begin
                  len_in[j] = cmd.len;
               end
            end
            fba_pkg::FL_INSERT: begin
               if (j == int'(cmd.idx)) begin
                  start_in[j] = cmd.start;
                  len_in[j]   = cmd.len;
               end else if (j > int'(cmd.idx)) begin
                  start_in[j] = start_ff[(j + fba_pkg::FREE_DEPTH - 1) % fba_pkg::FREE_DEPTH];
                  len_in[j]   = len_ff[(j + fba_pkg::FREE_DEPTH - 1) % fba_pkg::FREE_DEPTH];
               end
            end
            default: begin
            end
         endcase
      end
      case (cmd.op)
         fba_pkg::FL_REMOVE, fba_pkg::FL_MERGE: count_in = count_ff - 1'b1;
         fba_pkg::FL_INSERT:                    count_in = count_ff + 1'b1;
         default:                               count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= fba_pkg::FCNT_BITS'(fba_pkg::INIT_COUNT);
         for (int j = 0; j < fba_pkg::FREE_DEPTH; j++) begin
            start_ff[j] <= fba_pkg::init_start(j);
            len_ff[j]   <= fba_pkg::init_len(j);
         end
      end else begin
         count_ff <= count_in;
         for (int j = 0; j < fba_pkg::FREE_DEPTH; j++) begin
            start_ff[j] <= start_in[j];
            len_ff[j]   <= len_in[j];
         end
      end
   end

   assign rd_start = start_ff[rd_idx];
   assign rd_len   = len_ff[rd_idx];
   assign count    = count_ff;

   `FBA_ASSERT_NOW(a_fl_no_insert_full, clock, reset, cmd.op == fba_pkg::FL_INSERT, count_ff < fba_pkg::FCNT_BITS'(fba_pkg::FREE_DEPTH))
   `FBA_ASSERT_NOW(a_fl_no_remove_empty, clock, reset, cmd.op == fba_pkg::FL_REMOVE || cmd.op == fba_pkg::FL_MERGE, count_ff != '0)
   `FBA_ASSERT_NEXT(a_fl_insert_count, clock, reset, cmd.op == fba_pkg::FL_INSERT, count_ff == $past(count_ff) + 1'b1)

endmodule

`default_nettype wire

FILE: tb/sv/fit_block_allocator_tb.sv
// Self-checking testbench for fit_block_allocator: predictor, stimulus, checks.
// Depends on fba_pkg and the fit_block_allocator RTL.
`timescale 1ns / 100ps

module fit_block_allocator_tb;

   localparam logic [fba_pkg::TYPE_BITS-1:0] REQ_UNKNOWN = 2'd3;
   localparam int LEN_MAX = 16777216;

   typedef struct {
      logic [fba_pkg::TYPE_BITS-1:0] kind;
      logic [fba_pkg::ID_BITS-1:0]   owner;
      logic [fba_pkg::ID_BITS-1:0]   tag;
      fba_pkg::len_type              size;
   } alloc_req_type;

   typedef struct {
      logic [fba_pkg::STAT_BITS-1:0]  status;
      fba_pkg::addr_type              addr;
      logic [fba_pkg::FREED_BITS-1:0] freed;
   } alloc_rsp_type;

   // DUT ports
   logic clock, reset, start, busy;
   logic [fba_pkg::TYPE_BITS-1:0] req_type;
   logic [fba_pkg::ID_BITS-1:0] req_owner_id, req_block_id;
   fba_pkg::len_type req_size;
   logic rsp_strobe;
   logic [fba_pkg::STAT_BITS-1:0] rsp_status;
   fba_pkg::addr_type rsp_alloc_addr;
   logic [fba_pkg::FREED_BITS-1:0] rsp_freed_count;
   logic csr_we;
   logic [fba_pkg::CSR_IDX_BITS-1:0] csr_index;
   fba_pkg::len_type csr_wdata;

   fit_block_allocator DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_owner_id(req_owner_id),
      .req_block_id(req_block_id), .req_size(req_size),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_alloc_addr(rsp_alloc_addr), .rsp_freed_count(rsp_freed_count),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow allocator state
   bit                          mdl_best_fit;
   fba_pkg::len_type            mdl_merge_limit;
   fba_pkg::addr_type           fb_start [fba_pkg::FREE_DEPTH];
   fba_pkg::len_type            fb_len [fba_pkg::FREE_DEPTH];
   int                          fb_count;
   fba_pkg::addr_type           ub_start [fba_pkg::USED_DEPTH];
   fba_pkg::len_type            ub_len [fba_pkg::USED_DEPTH];
   logic [fba_pkg::ID_BITS-1:0] ub_owner [fba_pkg::USED_DEPTH];
   logic [fba_pkg::ID_BITS-1:0] ub_tag [fba_pkg::USED_DEPTH];
   bit                          ub_valid [fba_pkg::USED_DEPTH];

   alloc_req_type pending_q [$];
   alloc_rsp_type expected_q [$];
   int  idle_pct;
   int  alloc_pct;    // share of allocates in random traffic
   bit  took;         // a request transfer happened at the last rising edge
   bit  failed;

   function automatic void shadow_reset();
      for (int i = 0; i < fba_pkg::FREE_DEPTH; i++) begin
         fb_start[i] = fba_pkg::init_start(i);
         fb_len[i] = fba_pkg::init_len(i);
      end
      fb_count = fba_pkg::INIT_COUNT;
      for (int i = 0; i < fba_pkg::USED_DEPTH; i++) ub_valid[i] = 0;
      mdl_best_fit = 0;
      mdl_merge_limit = fba_pkg::MERGE_LIMIT_RESET;
   endfunction

   function automatic void free_drop(int k);
      for (int i = k; i + 1 < fb_count; i++) begin
         fb_start[i] = fb_start[i+1];
         fb_len[i] = fb_len[i+1];
      end
      fb_count--;
      fb_start[fb_count] = '0;
      fb_len[fb_count] = '0;
   endfunction

   function automatic bit free_add(fba_pkg::addr_type s, fba_pkg::len_type l);
      int p;
      p = 0;
      if (fb_count >= fba_pkg::FREE_DEPTH) return 0;
      while (p < fb_count && !(s < fb_start[p])) p++;
      for (int i = fb_count; i > p; i--) begin
         fb_start[i] = fb_start[i-1];
         fb_len[i] = fb_len[i-1];
      end
      fb_start[p] = s;
      fb_len[p] = l;
      fb_count++;
      return 1;
   endfunction

   function automatic void used_drop(int k, int n);
      for (int i = k; i + 1 < n; i++) begin
         ub_start[i] = ub_start[i+1];
         ub_len[i] = ub_len[i+1];
         ub_owner[i] = ub_owner[i+1];
         ub_tag[i] = ub_tag[i+1];
      end
      ub_valid[n-1] = 0;
   endfunction

   // coalesce touching neighbors low to high where the sum stays within the cap
   function automatic void coalesce();
      int i;
      logic [25:0] fend, sum;
      i = 0;
      while (i + 1 < fb_count) begin
         fend = 26'(fb_start[i]) + 26'(fb_len[i]);
         sum = 26'(fb_len[i]) + 26'(fb_len[i+1]);
         if (fend == 26'(fb_start[i+1]) && sum <= 26'(mdl_merge_limit)) begin
            fb_len[i] = sum[24:0];
            free_drop(i + 1);
         end else begin
            i++;
         end
      end
   endfunction

   function automatic alloc_rsp_type predict_rsp(alloc_req_type rq);
      alloc_rsp_type r;
      int n, k;
      bit found, full;
      r = '{fba_pkg::ST_OK, '0, '0};
      n = 0;
      while (n < fba_pkg::USED_DEPTH && ub_valid[n]) n++;
      case (rq.kind)
         fba_pkg::REQ_ALLOC: begin
            if (n >= fba_pkg::USED_DEPTH) begin
               r.status = fba_pkg::ST_FULL;
            end else begin
               found = 0;
               k = 0;
               for (int i = 0; i < fb_count; i++) begin
                  if (fb_len[i] >= rq.size) begin
                     if (!found || (mdl_best_fit && fb_len[i] < fb_len[k])) k = i;
                     found = 1;
                     if (!mdl_best_fit) break;
                  end
               end
               if (!found) begin
                  r.status = fba_pkg::ST_NO_SPACE;
               end else begin
                  r.addr = fb_start[k];
                  fb_start[k] = fb_start[k] + rq.size[fba_pkg::ADDR_BITS-1:0];
                  fb_len[k] = fb_len[k] - rq.size;
                  if (fb_len[k] == 0) free_drop(k);
                  for (int i = n; i > 0; i--) begin
                     ub_start[i] = ub_start[i-1];
                     ub_len[i] = ub_len[i-1];
                     ub_owner[i] = ub_owner[i-1];
                     ub_tag[i] = ub_tag[i-1];
                  end
                  ub_start[0] = r.addr;
                  ub_len[0] = rq.size;
                  ub_owner[0] = rq.owner;
                  ub_tag[0] = rq.tag;
                  ub_valid[n] = 1;
               end
            end
         end
         fba_pkg::REQ_FREE: begin
            k = 0;
            while (k < n && !(ub_owner[k] == rq.owner && ub_tag[k] == rq.tag)) k++;
            if (k >= n) r.status = fba_pkg::ST_NOT_FOUND;
            else if (!free_add(ub_start[k], ub_len[k])) r.status = fba_pkg::ST_FULL;
            else begin
               coalesce();
               used_drop(k, n);
               r.freed = 1;
            end
         end
         fba_pkg::REQ_TERM: begin
            full = 0;
            k = 0;
            while (k < n) begin
               if (ub_owner[k] == rq.owner) begin
                  if (!free_add(ub_start[k], ub_len[k])) begin
                     full = 1;
                     break;
                  end
                  used_drop(k, n);
                  n--;
                  r.freed++;
               end else begin
                  k++;
               end
            end
            if (r.freed > 0) coalesce();
            r.status = full ? fba_pkg::ST_FULL :
                       (r.freed == 0 ? fba_pkg::ST_NOT_FOUND : fba_pkg::ST_OK);
         end
         default: ;
      endcase
      return r;
   endfunction

   // clock
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // request driver: presents the next queued request after each transfer
   always @(negedge clock) begin
      if (!reset && (!start || took)) begin
         if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            alloc_req_type rq;
            rq = pending_q.pop_front();
            req_type <= rq.kind;
            req_owner_id <= rq.owner;
            req_block_id <= rq.tag;
            req_size <= rq.size;
            start <= 1;
         end else begin
            start <= 0;
         end
      end
   end

   // monitor: predicts on each request transfer, checks each response
   always @(posedge clock) begin
      alloc_rsp_type exp_r;
      alloc_req_type rq;
      took <= start && !busy && !reset;
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response status=%0d addr=%0h freed=%0d",
                     $time, rsp_status, rsp_alloc_addr, rsp_freed_count);
            failed = 1;
         end else begin
            exp_r = expected_q.pop_front();
            if (rsp_status !== exp_r.status) begin
               $display("%0t: status expected %0d actual %0d", $time, exp_r.status, rsp_status);
               failed = 1;
            end
            if (rsp_alloc_addr !== exp_r.addr) begin
               $display("%0t: alloc_addr expected %0h actual %0h",
                        $time, exp_r.addr, rsp_alloc_addr);
               failed = 1;
            end
            if (rsp_freed_count !== exp_r.freed) begin
               $display("%0t: freed_count expected %0d actual %0d",
                        $time, exp_r.freed, rsp_freed_count);
               failed = 1;
            end
         end
      end
      // request checked after the response so a same-edge result pops first
      if (!reset && start && !busy) begin
         rq = '{req_type, req_owner_id, req_block_id, req_size};
         expected_q.insert(expected_q.size(), predict_rsp(rq));
      end
   end

   task automatic push_req(logic [fba_pkg::TYPE_BITS-1:0] kind, int owner, int tag, int size);
      alloc_req_type rq;
      rq = '{kind, owner[fba_pkg::ID_BITS-1:0], tag[fba_pkg::ID_BITS-1:0],
             size[fba_pkg::LEN_BITS-1:0]};
      pending_q.insert(pending_q.size(), rq);
   endtask

   // random traffic: few owners and tags so frees hit, with stray ids mixed in
   task automatic push_random(int count);
      int pick, owner, tag, size;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         owner = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(3);
         tag = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(3);
         case ($urandom_range(19))
            0: size = 0;
            1: size = LEN_MAX;
            2: size = $urandom_range(LEN_MAX);
            3, 4: size = $urandom_range(4 * fba_pkg::MB);
            default: size = $urandom_range(fba_pkg::MB / 2);
         endcase
         if (pick < alloc_pct) push_req(fba_pkg::REQ_ALLOC, owner, tag, size);
         else if (pick < alloc_pct + (100 - alloc_pct) * 7 / 10)
            push_req(fba_pkg::REQ_FREE, owner, tag, size);
         else if (pick < 97) push_req(fba_pkg::REQ_TERM, owner, tag, size);
         else push_req(REQ_UNKNOWN, owner, tag, size);
      end
   endtask

   // drain every pending transfer and response, then let the block settle
   task automatic drain();
      while (pending_q.size() > 0 || start || expected_q.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [fba_pkg::CSR_IDX_BITS-1:0] idx, int value);
      @(negedge clock);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = value[fba_pkg::LEN_BITS-1:0];
      @(posedge clock);
      if (idx == fba_pkg::CSR_FIT_MODE) mdl_best_fit = value[0];
      else mdl_merge_limit = value[fba_pkg::LEN_BITS-1:0];
      @(negedge clock);
      csr_we = 0;
   endtask

   // run limit
   initial begin
      #40ms;
      $display("FAILURE");
      $finish;
   end

   initial begin
      failed = 0;
      took = 0;
      idle_pct = 0;
      alloc_pct = 50;
      reset = 1;
      start = 0;
      req_type = '0;
      req_owner_id = '0;
      req_block_id = '0;
      req_size = '0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      shadow_reset();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes, each request type, corner statuses
      push_req(fba_pkg::REQ_ALLOC, 0, 0, 0);                  // zero size allocate
      push_req(fba_pkg::REQ_ALLOC, 255, 255, LEN_MAX);        // too large
      push_req(fba_pkg::REQ_ALLOC, 1, 1, fba_pkg::MB);        // exact fit empties a block
      push_req(fba_pkg::REQ_ALLOC, 1, 2, 3 * fba_pkg::MB);
      push_req(fba_pkg::REQ_ALLOC, 1, 1, 5);
      push_req(fba_pkg::REQ_FREE, 9, 9, 0);                   // not found
      push_req(fba_pkg::REQ_TERM, 77, 0, 0);                  // not found
      push_req(fba_pkg::REQ_FREE, 1, 1, 0);                   // newest match goes first
      push_req(fba_pkg::REQ_ALLOC, 2, 0, 4 * fba_pkg::MB);
      push_req(fba_pkg::REQ_ALLOC, 2, 1, 4 * fba_pkg::MB);
      push_req(fba_pkg::REQ_TERM, 2, 0, 0);
      push_req(REQ_UNKNOWN, 255, 255, LEN_MAX);               // ignored
      push_req(fba_pkg::REQ_TERM, 1, 0, 0);
      push_req(fba_pkg::REQ_FREE, 0, 0, 0);
      push_req(fba_pkg::REQ_ALLOC, 3, 3, 16 * fba_pkg::MB - 1); // no free block fits
      drain();

      // merge cap large, best fit off, no gaps
      csr_write(fba_pkg::CSR_MERGE_LIMIT, LEN_MAX);
      push_random(240);
      drain();

      // merge cap of 1: fragment the free list, then hammer the tables
      csr_write(fba_pkg::CSR_FIT_MODE, 1);
      csr_write(fba_pkg::CSR_MERGE_LIMIT, 1);
      idle_pct = 86;
      alloc_pct = 85;
      push_random(150);
      alloc_pct = 25;
      push_random(100);
      drain();

      csr_write(fba_pkg::CSR_MERGE_LIMIT, 0);
      idle_pct = 26;
      alloc_pct = 60;
      push_random(240);
      drain();

      csr_write(fba_pkg::CSR_FIT_MODE, 0);
      csr_write(fba_pkg::CSR_MERGE_LIMIT, 4 * fba_pkg::MB);
      idle_pct = 0;
      alloc_pct = 80;
      push_random(240);
      drain();

      csr_write(fba_pkg::CSR_FIT_MODE, 1);
      csr_write(fba_pkg::CSR_MERGE_LIMIT, $urandom_range(1, 8 * fba_pkg::MB));
      idle_pct = 86;
      alloc_pct = 50;
      push_random(240);
      drain();

      idle_pct = 0;
      push_random(240);
      drain();
      repeat (50) @(posedge clock);

      if (!failed) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/fba_pkg.sv
src/fba_free_list.sv
src/fit_block_allocator.sv
tb/sv/fit_block_allocator_tb.sv
